// ----- src/bhmt_pkg.sv -----
// ----------------------------------------------------------------------------
// bhmt_pkg: shared types and constants for the button hold mode toggle
// Item structs, state struct, flag bit positions, group and light codes.
// ----------------------------------------------------------------------------
package bhmt_pkg;

    localparam int CntW    = 16;
    localparam int FlagW   = 5;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 16;

    localparam logic [CntW-1:0] HoldThresholdReset = 16'd3000;
    localparam logic [FlagW-1:0] StartFlagsReset   = 5'd0;

    // mode flag bit positions
    localparam int FlagKb  = 0;
    localparam int FlagJoy = 1;
    localparam int FlagDig = 2;
    localparam int FlagFrc = 3;
    localparam int FlagLed = 4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegHoldThreshold = 2'd0;
    localparam logic [CfgIdxW-1:0] RegStartFlags    = 2'd1;

    // feedback group codes
    localparam logic [1:0] GrpInput = 2'd0;
    localparam logic [1:0] GrpTt    = 2'd1;
    localparam logic [1:0] GrpLed   = 2'd2;

    // feedback indicator codes
    localparam logic [1:0] LightBtn2 = 2'd0;
    localparam logic [1:0] LightBtn4 = 2'd1;
    localparam logic [1:0] LightBtn6 = 2'd2;

    typedef struct packed {
        logic btn_start;
        logic btn_select;
        logic btn_one;
        logic btn_three;
        logic btn_five;
    } t_in_item;

    typedef struct packed {
        logic       keyboard_enable;
        logic       joy_force_disable;
        logic       digital_tt_enable;
        logic       analog_tt_force;
        logic       leds_off;
        logic       tt_reversed;
        logic       feedback_valid;
        logic [1:0] feedback_group;
        logic [1:0] feedback_light;
    } t_out_item;

    typedef struct packed {
        logic [CntW-1:0]  input_cnt;
        logic [CntW-1:0]  tt_cnt;
        logic [CntW-1:0]  led_cnt;
        logic [FlagW-1:0] mode_flags;
        logic             reverse_flag;
    } t_state;

endpackage

// ----- src/bhmt_step.sv -----
// ----------------------------------------------------------------------------
// bhmt_step: per-sample update
// Count holds, detect threshold matches, apply group toggles, form the result.
// ----------------------------------------------------------------------------
module bhmt_step import bhmt_pkg::*; (
    input  t_in_item        i_item,
    input  t_state          i_state,
    input  logic [CntW-1:0] i_threshold,
    output t_state          o_state,
    output t_out_item       o_item
);

    t_state     s;
    logic       fb_valid;
    logic [1:0] fb_group;
    logic [1:0] fb_light;
    logic       combo;

    always_comb begin
        s        = i_state;
        fb_valid = 1'b0;
        fb_group = GrpInput;
        fb_light = LightBtn2;
        combo    = i_item.btn_start & i_item.btn_select;

        // count: only the first held combo button advances
        if (combo) begin
            if (i_item.btn_one) begin
                s.input_cnt = s.input_cnt + 1'b1;
            end else if (i_item.btn_three) begin
                s.tt_cnt = s.tt_cnt + 1'b1;
            end else if (i_item.btn_five) begin
                s.led_cnt = s.led_cnt + 1'b1;
            end
        end else begin
            s.input_cnt = '0;
            s.tt_cnt    = '0;
            s.led_cnt   = '0;
        end

        if (i_threshold != '0) begin
            // input group: controller <-> keyboard
            if (s.input_cnt == i_threshold) begin
                if (!s.mode_flags[FlagKb] && !s.mode_flags[FlagJoy]) begin
                    s.mode_flags[FlagKb]  = 1'b1;
                    s.mode_flags[FlagJoy] = 1'b1;
                    fb_light = LightBtn4;
                end else begin
                    s.mode_flags[FlagKb]  = 1'b0;
                    s.mode_flags[FlagJoy] = 1'b0;
                    fb_light = LightBtn2;
                end
                fb_group    = GrpInput;
                fb_valid    = 1'b1;
                s.input_cnt = '0;
            end
            // turntable group: analog -> digital -> analog reversed
            if (s.tt_cnt == i_threshold) begin
                if (!s.mode_flags[FlagDig] && !s.mode_flags[FlagFrc] && !s.reverse_flag) begin
                    s.mode_flags[FlagDig] = 1'b1;
                    fb_light = LightBtn4;
                end else if (s.mode_flags[FlagDig] && !s.mode_flags[FlagFrc]) begin
                    s.mode_flags[FlagDig] = 1'b0;
                    s.reverse_flag        = 1'b1;
                    fb_light = LightBtn6;
                end else begin
                    s.mode_flags[FlagDig] = 1'b0;
                    s.mode_flags[FlagFrc] = 1'b0;
                    s.reverse_flag        = 1'b0;
                    fb_light = LightBtn2;
                end
                fb_group = GrpTt;
                fb_valid = 1'b1;
                s.tt_cnt = '0;
            end
            // LED group: on <-> off
            if (s.led_cnt == i_threshold) begin
                if (s.mode_flags[FlagLed]) begin
                    s.mode_flags[FlagLed] = 1'b0;
                    fb_light = LightBtn2;
                end else begin
                    s.mode_flags[FlagLed] = 1'b1;
                    fb_light = LightBtn4;
                end
                fb_group  = GrpLed;
                fb_valid  = 1'b1;
                s.led_cnt = '0;
            end
        end
    end

    assign o_state = s;

    always_comb begin
        o_item.keyboard_enable   = s.mode_flags[FlagKb];
        o_item.joy_force_disable = s.mode_flags[FlagJoy];
        o_item.digital_tt_enable = s.mode_flags[FlagDig];
        o_item.analog_tt_force   = s.mode_flags[FlagFrc];
        o_item.leds_off          = s.mode_flags[FlagLed];
        o_item.tt_reversed       = s.reverse_flag;
        o_item.feedback_valid    = fb_valid;
        o_item.feedback_group    = fb_group;
        o_item.feedback_light    = fb_light;
    end

endmodule

// ----- src/button_hold_mode_toggle.sv -----
// ----------------------------------------------------------------------------
// button_hold_mode_toggle: hold-to-toggle mode control for a button panel
// Samples are registered, updated against the hold counters and mode flags,
// and the result (flags plus toggle feedback) is held in an output register.
// ----------------------------------------------------------------------------
// Path: an accepted sample is held in the input register, then its result
//   in the result register; one item per cycle sustained while the result
//   channel is not stalled, set by the single state-update path between them.
// Reset (i_rst_n low, synchronous): both stages empty, counters and reverse
//   flag cleared, hold threshold 3000, mode flags 0.
// ----------------------------------------------------------------------------
module button_hold_mode_toggle import bhmt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgDatW-1:0] i_cfg_data
);

    // input stage
    logic      r_in_valid;
    t_in_item  r_in;
    // result stage
    logic      r_out_valid;
    t_out_item r_out;
    // block state and threshold
    t_state          r_state;
    logic [CntW-1:0] r_threshold;

    t_state    n_state;
    t_out_item n_out;
    logic      advance;

    // Move the registered sample into the result stage whenever that stage
    // is empty or being drained this cycle; the state commits on the same edge.
    assign advance     = r_in_valid & (~r_out_valid | i_out_ready);
    // Take a new sample whenever the input stage empties this cycle.
    assign o_in_ready  = ~r_in_valid | advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    bhmt_step u_step (
        .i_item      (r_in),
        .i_state     (r_state),
        .i_threshold (r_threshold),
        .o_state     (n_state),
        .o_item      (n_out)
    );

    // control state, counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid               <= 1'b0;
            r_out_valid              <= 1'b0;
            r_threshold              <= HoldThresholdReset;
            r_state.input_cnt        <= '0;
            r_state.tt_cnt           <= '0;
            r_state.led_cnt          <= '0;
            r_state.mode_flags       <= StartFlagsReset;
            r_state.reverse_flag     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Writes must come only while idle; the block does not enforce it.
            // A start_flags write sets mode flags, not counters or reverse flag.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegHoldThreshold: r_threshold <= i_cfg_data;
                    RegStartFlags:    r_state.mode_flags <= i_cfg_data[FlagW-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload: hold a sample until it moves on, load a result on advance
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- src/bhmt_checker.sv -----
// ----------------------------------------------------------------------------
// bhmt_checker: port-level checks for the button hold mode toggle
// Watches the result channel for handshake and feedback consistency.
// ----------------------------------------------------------------------------
module bhmt_checker import bhmt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // no toggle means zero feedback fields
    a_fb_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.feedback_valid |->
            o_out_item.feedback_group == GrpInput && o_out_item.feedback_light == LightBtn2)
        else $error("feedback fields set without a toggle");

    // an LED toggle reported last leaves the flag matching the indicator
    a_led_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.feedback_valid && o_out_item.feedback_group == GrpLed |->
            (o_out_item.leds_off == (o_out_item.feedback_light == LightBtn4)))
        else $error("LED flag disagrees with LED feedback");

    // an input-group toggle reported last sets keyboard and joy-disable together
    a_input_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.feedback_valid && o_out_item.feedback_group == GrpInput |->
            o_out_item.keyboard_enable == o_out_item.joy_force_disable &&
            o_out_item.keyboard_enable == (o_out_item.feedback_light == LightBtn4))
        else $error("input mode flags disagree with input feedback");

endmodule

bind button_hold_mode_toggle bhmt_checker u_bhmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
